[hw/rtl/pbfl_pkg.sv]
// Package with types, constants and controller encodings for the budget flow limiter.
`timescale 1ns / 1ps
`default_nettype none
package pbfl_pkg;

  localparam int QueueDepthDefault = 16;
  localparam int DATA_W = 32;
  localparam int FRAG_W = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_TO_CLEAR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REFRESH_TICKS = 1'd1;

  localparam logic [DATA_W-1:0] SIZE_TO_CLEAR_RESET = 32'd65536;
  localparam logic [DATA_W-1:0] REFRESH_TICKS_RESET = 32'd1000;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic              is_fragmented;
    logic [DATA_W-1:0] payload_length;
    logic [FRAG_W-1:0] fragment_size;
    logic [FRAG_W-1:0] fragments_ready;
    logic              last_in_batch;
  } in_word_t;

  typedef struct packed {
    logic              admitted;
    logic [FRAG_W-1:0] fragments_admitted;
    logic              wake;
    logic              queue_overflow;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_DIV,
    ST_FIT,
    ST_MUL,
    ST_APPLY,
    ST_BATCH,
    ST_ENQ_RD,
    ST_ENQ_WR,
    ST_TICK,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_POP_RD,
    ST_POP_CHK,
    ST_TICK_APPLY,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load_in;
    logic eval_whole;
    logic div_start;
    logic fit_set;
    logic mul;
    logic apply_frag;
    logic batch_end;
    logic enq_rd;
    logic enq_wr;
    logic tick_inc;
    logic scan_rd;
    logic scan_chk;
    logic pop_rd;
    logic pop_chk;
    logic tick_apply;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic opcode;
    logic frag;
    logic blocked;
    logic fsize_zero;
    logic last;
    logic div_done;
    logic spend_nz;
    logic count_nz;
    logic scan_more;
    logic head_zero;
    logic out_full;
  } status_t;

endpackage
`default_nettype wire

[hw/rtl/pbfl_div.sv]
// Radix-2 restoring divider, 32-bit dividend by 16-bit divisor, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module pbfl_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [pbfl_pkg::DATA_W-1:0] dividend,
  input  logic [pbfl_pkg::FRAG_W-1:0] divisor,
  output logic                        done,
  output logic [pbfl_pkg::DATA_W-1:0] quotient
);

  localparam int STEP_W = $clog2(pbfl_pkg::DATA_W + 1);

  logic                        busy;
  logic [STEP_W-1:0]           steps;
  logic [pbfl_pkg::FRAG_W-1:0] rem;
  logic [pbfl_pkg::FRAG_W-1:0] dsr;
  logic [pbfl_pkg::FRAG_W:0]   rem_shift;
  logic                        fits;

  assign rem_shift = {rem, quotient[pbfl_pkg::DATA_W-1]};
  assign fits = rem_shift >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        steps <= '0;
      end else if (busy) begin
        steps <= steps + 1'b1;
        if (steps == STEP_W'(pbfl_pkg::DATA_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dsr <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (fits) begin
        rem <= pbfl_pkg::FRAG_W'(rem_shift - {1'b0, dsr});
      end else begin
        rem <= rem_shift[pbfl_pkg::FRAG_W-1:0];
      end
      quotient <= {quotient[pbfl_pkg::DATA_W-2:0], fits};
    end
  end

endmodule
`default_nettype wire

[hw/rtl/pbfl_datapath.sv]
// Datapath: budget registers, restore queue memory, fit arithmetic and output register.
`timescale 1ns / 1ps
`default_nettype none
module pbfl_datapath #(
  parameter int QUEUE_DEPTH = pbfl_pkg::QueueDepthDefault
) (
  input  logic                           clk,
  input  logic                           rst,
  input  pbfl_pkg::cmd_t                 cmd,
  output pbfl_pkg::status_t              status,
  input  pbfl_pkg::in_word_t             in_word,
  input  logic                           cfg_we,
  input  logic [pbfl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pbfl_pkg::DATA_W-1:0]    cfg_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output pbfl_pkg::out_word_t            out_word
);

  localparam int IDX_W = QUEUE_DEPTH > 1 ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int DW = pbfl_pkg::DATA_W;
  localparam int FW = pbfl_pkg::FRAG_W;

  pbfl_pkg::in_word_t  cur;
  pbfl_pkg::out_word_t res;

  logic [DW-1:0] size_to_clear;
  logic [DW-1:0] refresh_ticks;
  logic [DW-1:0] spent_bytes;
  logic [DW-1:0] spent_at_batch_start;
  logic          batch_blocked;
  logic [DW-1:0] current_tick;
  logic [IDX_W-1:0] queue_head;
  logic [CNT_W-1:0] queue_count;
  logic [CNT_W-1:0] scan_idx;
  logic [DW:0]      total;
  logic             fired;
  logic [DW-1:0]    spend;
  logic [FW-1:0]    fit;
  logic [DW-1:0]    prod;

  logic [DW-1:0] amt_mem [QUEUE_DEPTH];
  logic [DW-1:0] dl_mem [QUEUE_DEPTH];
  logic [DW-1:0] rd_amt;
  logic [DW-1:0] rd_dl;

  logic [DW-1:0]    left;
  logic [DW:0]      whole_sum;
  logic [DW-1:0]    spend_now;
  logic [DW-1:0]    deadline;
  logic             enq_merge;
  logic             enq_full;
  logic [CNT_W-1:0] off;
  logic [CNT_W:0]   slot_sum;
  logic [IDX_W-1:0] addr;
  logic [DW:0]      merged_sum;
  logic [DW-1:0]    merged;
  logic [DW+1:0]    total_sum;
  logic             due;
  logic             div_done;
  logic [DW-1:0]    quotient;

  pbfl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (left),
    .divisor  (cur.fragment_size),
    .done     (div_done),
    .quotient (quotient)
  );

  assign left = size_to_clear > spent_bytes ? size_to_clear - spent_bytes : '0;
  assign whole_sum = {1'b0, spent_bytes} + {1'b0, cur.payload_length};
  assign spend_now = spent_bytes > spent_at_batch_start ?
                     spent_bytes - spent_at_batch_start : '0;
  assign deadline = current_tick + (refresh_ticks == '0 ? DW'(1) : refresh_ticks);
  assign enq_merge = (queue_count != '0) && (rd_amt != '0) && (rd_dl == deadline);
  assign enq_full = queue_count >= CNT_W'(QUEUE_DEPTH);
  assign merged_sum = {1'b0, rd_amt} + {1'b0, spend};
  assign merged = merged_sum[DW] ? '1 : merged_sum[DW-1:0];
  assign total_sum = {1'b0, total} + {2'b00, rd_amt};
  assign due = (rd_amt != '0) && (rd_dl == current_tick);

  always_comb begin
    off = '0;
    if (cmd.enq_rd) begin
      off = queue_count - 1'b1;
    end else if (cmd.enq_wr) begin
      off = (enq_merge || enq_full) ? queue_count - 1'b1 : queue_count;
    end else if (cmd.scan_rd || cmd.scan_chk) begin
      off = scan_idx;
    end
    slot_sum = {1'b0, off} + (CNT_W + 1)'(queue_head);
    if (slot_sum >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
      slot_sum = slot_sum - (CNT_W + 1)'(QUEUE_DEPTH);
    end
    addr = slot_sum[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.enq_wr) begin
      amt_mem[addr] <= enq_merge || enq_full ? merged : spend;
      if (!enq_merge) begin
        dl_mem[addr] <= deadline;
      end
    end else if (cmd.scan_chk && due) begin
      amt_mem[addr] <= '0;
    end
    if (cmd.enq_rd || cmd.scan_rd || cmd.pop_rd) begin
      rd_amt <= amt_mem[addr];
      rd_dl <= dl_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_to_clear <= pbfl_pkg::SIZE_TO_CLEAR_RESET;
      refresh_ticks <= pbfl_pkg::REFRESH_TICKS_RESET;
      spent_bytes <= '0;
      spent_at_batch_start <= '0;
      batch_blocked <= 1'b0;
      current_tick <= '0;
      queue_head <= '0;
      queue_count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          pbfl_pkg::CFG_SIZE_TO_CLEAR: size_to_clear <= cfg_data;
          pbfl_pkg::CFG_REFRESH_TICKS: refresh_ticks <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.eval_whole) begin
        if (whole_sum <= {1'b0, size_to_clear}) begin
          spent_bytes <= whole_sum[DW-1:0];
        end else begin
          batch_blocked <= 1'b1;
        end
      end
      if (cmd.apply_frag) begin
        if (fit != '0) begin
          spent_bytes <= spent_bytes + prod;
        end else begin
          batch_blocked <= 1'b1;
        end
      end
      if (cmd.batch_end) begin
        batch_blocked <= 1'b0;
        spent_at_batch_start <= spent_bytes;
      end
      if (cmd.enq_wr && !enq_merge && !enq_full) begin
        queue_count <= queue_count + 1'b1;
      end
      if (cmd.tick_inc) begin
        current_tick <= current_tick + 1'b1;
      end
      if (cmd.pop_chk && rd_amt == '0) begin
        queue_head <= queue_head == IDX_W'(QUEUE_DEPTH - 1) ? '0 : queue_head + 1'b1;
        queue_count <= queue_count - 1'b1;
      end
      if (cmd.tick_apply && fired) begin
        spent_bytes <= total >= {1'b0, spent_bytes} ? '0 : spent_bytes - total[DW-1:0];
        spent_at_batch_start <= total >= {1'b0, spent_at_batch_start} ?
                                '0 : spent_at_batch_start - total[DW-1:0];
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cur <= in_word;
      res <= '0;
    end
    if (cmd.eval_whole && whole_sum <= {1'b0, size_to_clear}) begin
      res.admitted <= 1'b1;
    end
    if (cmd.fit_set) begin
      if (cur.fragment_size == '0 || quotient > DW'(cur.fragments_ready)) begin
        fit <= cur.fragments_ready;
      end else begin
        fit <= quotient[FW-1:0];
      end
    end
    if (cmd.mul) begin
      prod <= fit * cur.fragment_size;
    end
    if (cmd.apply_frag && fit != '0) begin
      res.admitted <= 1'b1;
      res.fragments_admitted <= fit;
    end
    if (cmd.batch_end) begin
      spend <= spend_now;
    end
    if (cmd.enq_wr && !enq_merge && enq_full) begin
      res.queue_overflow <= 1'b1;
    end
    if (cmd.tick_inc) begin
      scan_idx <= '0;
      total <= '0;
      fired <= 1'b0;
    end
    if (cmd.scan_chk) begin
      scan_idx <= scan_idx + 1'b1;
      if (due) begin
        fired <= 1'b1;
        total <= total_sum > {1'b0, 1'b1, DW'(0)} ? {1'b1, DW'(0)} : total_sum[DW:0];
      end
    end
    if (cmd.tick_apply) begin
      res.wake <= fired;
    end
    if (cmd.out_load) begin
      out_word <= res;
    end
  end

  assign status.opcode = cur.opcode;
  assign status.frag = cur.is_fragmented;
  assign status.blocked = batch_blocked;
  assign status.fsize_zero = cur.fragment_size == '0;
  assign status.last = cur.last_in_batch;
  assign status.div_done = div_done;
  assign status.spend_nz = spend_now != '0;
  assign status.count_nz = queue_count != '0;
  assign status.scan_more = scan_idx < queue_count;
  assign status.head_zero = rd_amt == '0;
  assign status.out_full = out_valid && !out_ready;

endmodule
`default_nettype wire

[hw/rtl/pbfl_ctrl.sv]
// Controller state machine that sequences sample, batch end and tick handling.
`timescale 1ns / 1ps
`default_nettype none
module pbfl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  pbfl_pkg::status_t status,
  output pbfl_pkg::cmd_t    cmd
);

  pbfl_pkg::state_t state;
  pbfl_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pbfl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      pbfl_pkg::ST_IDLE: begin
        if (in_valid) state_next = pbfl_pkg::ST_DISPATCH;
      end
      pbfl_pkg::ST_DISPATCH: begin
        if (status.opcode == pbfl_pkg::OP_TICK) state_next = pbfl_pkg::ST_TICK;
        else if (status.blocked || !status.frag) state_next = pbfl_pkg::ST_BATCH;
        else if (status.fsize_zero) state_next = pbfl_pkg::ST_MUL;
        else state_next = pbfl_pkg::ST_DIV;
      end
      pbfl_pkg::ST_DIV: begin
        if (status.div_done) state_next = pbfl_pkg::ST_FIT;
      end
      pbfl_pkg::ST_FIT: state_next = pbfl_pkg::ST_MUL;
      pbfl_pkg::ST_MUL: state_next = pbfl_pkg::ST_APPLY;
      pbfl_pkg::ST_APPLY: state_next = pbfl_pkg::ST_BATCH;
      pbfl_pkg::ST_BATCH: begin
        if (status.last && status.spend_nz) begin
          state_next = status.count_nz ? pbfl_pkg::ST_ENQ_RD : pbfl_pkg::ST_ENQ_WR;
        end else begin
          state_next = pbfl_pkg::ST_FINISH;
        end
      end
      pbfl_pkg::ST_ENQ_RD: state_next = pbfl_pkg::ST_ENQ_WR;
      pbfl_pkg::ST_ENQ_WR: state_next = pbfl_pkg::ST_FINISH;
      pbfl_pkg::ST_TICK: state_next = pbfl_pkg::ST_SCAN_RD;
      pbfl_pkg::ST_SCAN_RD: begin
        state_next = status.scan_more ? pbfl_pkg::ST_SCAN_CHK : pbfl_pkg::ST_POP_RD;
      end
      pbfl_pkg::ST_SCAN_CHK: state_next = pbfl_pkg::ST_SCAN_RD;
      pbfl_pkg::ST_POP_RD: begin
        state_next = status.count_nz ? pbfl_pkg::ST_POP_CHK : pbfl_pkg::ST_TICK_APPLY;
      end
      pbfl_pkg::ST_POP_CHK: begin
        state_next = status.head_zero ? pbfl_pkg::ST_POP_RD : pbfl_pkg::ST_TICK_APPLY;
      end
      pbfl_pkg::ST_TICK_APPLY: state_next = pbfl_pkg::ST_FINISH;
      pbfl_pkg::ST_FINISH: begin
        if (!status.out_full) state_next = pbfl_pkg::ST_IDLE;
      end
      default: state_next = pbfl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      pbfl_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load_in = in_valid;
      end
      pbfl_pkg::ST_DISPATCH: begin
        if (status.opcode == pbfl_pkg::OP_SAMPLE && !status.blocked) begin
          cmd.eval_whole = !status.frag;
          cmd.fit_set = status.frag && status.fsize_zero;
          cmd.div_start = status.frag && !status.fsize_zero;
        end
      end
      pbfl_pkg::ST_FIT: cmd.fit_set = 1'b1;
      pbfl_pkg::ST_MUL: cmd.mul = 1'b1;
      pbfl_pkg::ST_APPLY: cmd.apply_frag = 1'b1;
      pbfl_pkg::ST_BATCH: cmd.batch_end = status.last;
      pbfl_pkg::ST_ENQ_RD: cmd.enq_rd = 1'b1;
      pbfl_pkg::ST_ENQ_WR: cmd.enq_wr = 1'b1;
      pbfl_pkg::ST_TICK: cmd.tick_inc = 1'b1;
      pbfl_pkg::ST_SCAN_RD: cmd.scan_rd = status.scan_more;
      pbfl_pkg::ST_SCAN_CHK: cmd.scan_chk = 1'b1;
      pbfl_pkg::ST_POP_RD: cmd.pop_rd = status.count_nz;
      pbfl_pkg::ST_POP_CHK: cmd.pop_chk = 1'b1;
      pbfl_pkg::ST_TICK_APPLY: cmd.tick_apply = 1'b1;
      pbfl_pkg::ST_FINISH: cmd.out_load = !status.out_full;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

[hw/rtl/payload_budget_flow_limiter_core.sv]
// Top level of the byte budget flow limiter: controller plus datapath.
`timescale 1ns / 1ps
`default_nettype none
//  Port group | Direction | Handshake           | Word
//  in_*       | input     | in_valid / in_ready | in_word_t: one sample or one tick
//  out_*      | output    | out_valid/out_ready | out_word_t: one result per input word
//  cfg_*      | input     | cfg_we              | cfg_index selects the register
//
//  A fragmented sample with a nonzero fragment size runs the 32-step shift-subtract
//  divider; a batch end that queues a restore reads the tail entry before writing it,
//  and skips the read when the queue is empty. A tick visits each queued entry and then
//  each entry dropped from the head, over one memory port.
//  Reset is synchronous and clears the queue pointers; the memory needs no clear.
//  A held output word does not stop intake; only the next result waits for it.
module payload_budget_flow_limiter_core #(
  parameter int QUEUE_DEPTH = pbfl_pkg::QueueDepthDefault
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  pbfl_pkg::in_word_t             in_word,
  output logic                           out_valid,
  input  logic                           out_ready,
  output pbfl_pkg::out_word_t            out_word,
  input  logic                           cfg_we,
  input  logic [pbfl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pbfl_pkg::DATA_W-1:0]    cfg_data
);

  pbfl_pkg::cmd_t    cmd;
  pbfl_pkg::status_t status;

  pbfl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  pbfl_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_word   (in_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule
`default_nettype wire
